// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/hsv2rgb_pkg.sv
// shared types, sector codes and divide-by-255 helper for the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

   localparam int SECTOR_W = 3;
   localparam int CHAN_W   = 8;

   typedef enum logic [SECTOR_W-1:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   // floor(y / 255) for y <= 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] y);
      logic [24:0] prod;
      logic [7:0]  qe;
      logic [16:0] rem;
      prod = {9'd0, y} + {1'b0, y, 8'd0};
      qe   = prod[23:16];
      rem  = {1'b0, y} - ({1'b0, qe, 8'd0} - {9'd0, qe});
      if (rem >= 17'd255) begin
         return qe + 8'd1;
      end
      return qe;
   endfunction

endpackage

`default_nettype wire

// File: rtl/hsv2rgb_queue.sv
// two-entry queue with push/full and pop/empty sides
`default_nettype none

module hsv2rgb_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] push_word,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      pop_word
);

   logic             head_valid_ff, head_valid_in;
   logic             tail_valid_ff, tail_valid_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             do_push;
   logic             do_pop;

   assign full     = tail_valid_ff;
   assign empty    = !head_valid_ff;
   assign pop_word = head_ff;
   assign do_push  = push && !tail_valid_ff;
   assign do_pop   = pop && head_valid_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (do_pop) begin
         if (tail_valid_ff) begin
            head_in       = tail_ff;
            tail_valid_in = 1'b0;
         end else if (do_push) begin
            head_in = push_word;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (do_push) begin
         if (!head_valid_ff) begin
            head_in       = push_word;
            head_valid_in = 1'b1;
         end else begin
            tail_in       = push_word;
            tail_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

// File: rtl/hsv2rgb_front.sv
// front end: takes hsv words, splits hue into sector and fraction
`default_nettype none

module hsv2rgb_front #(
   parameter int HUE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [HUE_BITS-1:0]    req_hue,
   input  wire logic [7:0]             req_saturation,
   input  wire logic [7:0]             req_brightness,
   output logic                        mid_push,
   input  wire logic                   mid_full,
   output logic [HUE_BITS+18:0]        mid_word
);

   localparam int WORD_W = HUE_BITS + 19;

   logic                  valid_ff, valid_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [HUE_BITS+2:0]   hue6;
   logic                  ready;
   logic                  take;

   // six times hue: integer part is the sector, the rest the fraction
   assign hue6  = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};
   assign ready = !valid_ff || !mid_full;
   assign take  = req_push && ready;

   assign req_full = !ready;
   assign mid_push = valid_ff;
   assign mid_word = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (valid_ff && !mid_full) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         word_in  = {hue6[HUE_BITS+2:HUE_BITS], hue6[HUE_BITS-1:0],
                     req_saturation, req_brightness};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

// File: rtl/hsv2rgb_back.sv
// back end: three-stage pipeline computing p, q, t and routing by sector
`default_nettype none

module hsv2rgb_back #(
   parameter int HUE_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [HUE_BITS+18:0] in_word,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hsv2rgb_pkg::rgb_type      out_pixel
);

   localparam logic [HUE_BITS+7:0] FULL = {8'd255, {HUE_BITS{1'b0}}};
   localparam logic [HUE_BITS:0]   ONE  = {1'b1, {HUE_BITS{1'b0}}};

   logic                    advance;

   logic [2:0]              in_sector;
   logic [HUE_BITS-1:0]     in_frac;
   logic [7:0]              in_sat;
   logic [7:0]              in_val;
   logic [HUE_BITS:0]       in_cfrac;

   // stage 1
   logic                    v1_ff, v1_in;
   logic [2:0]              sec1_ff;
   logic [7:0]              val1_ff;
   logic [HUE_BITS+7:0]     fs1_ff;
   logic [HUE_BITS+8:0]     fst1_ff;
   logic [15:0]             pn1_ff;

   // stage 2
   logic                    v2_ff, v2_in;
   logic [2:0]              sec2_ff;
   logic [7:0]              val2_ff;
   logic [15:0]             yp2_ff;
   logic [15:0]             yq2_ff;
   logic [15:0]             yt2_ff;
   logic [HUE_BITS+7:0]     nq;
   logic [HUE_BITS+8:0]     nt_wide;
   logic [HUE_BITS+15:0]    xq;
   logic [HUE_BITS+15:0]    xt;

   // stage 3
   logic                    v3_ff, v3_in;
   hsv2rgb_pkg::rgb_type    pix3_ff, pix3_in;
   logic [7:0]              p_val;
   logic [7:0]              q_val;
   logic [7:0]              t_val;

   assign advance  = !v3_ff || out_ready;
   assign in_ready = advance;

   assign in_sector = in_word[HUE_BITS+18:HUE_BITS+16];
   assign in_frac   = in_word[HUE_BITS+15:16];
   assign in_sat    = in_word[15:8];
   assign in_val    = in_word[7:0];
   assign in_cfrac  = ONE - {1'b0, in_frac};

   assign nq      = FULL - fs1_ff;
   assign nt_wide = {1'b0, FULL} - fst1_ff;
   assign xq      = {{(HUE_BITS+8){1'b0}}, val1_ff} * {8'd0, nq};
   assign xt      = {{(HUE_BITS+8){1'b0}}, val1_ff} * {8'd0, nt_wide[HUE_BITS+7:0]};

   assign p_val = hsv2rgb_pkg::div255(yp2_ff);
   assign q_val = hsv2rgb_pkg::div255(yq2_ff);
   assign t_val = hsv2rgb_pkg::div255(yt2_ff);

   assign v1_in = advance ? in_valid : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;
   assign v3_in = advance ? v2_ff : v3_ff;

   always_comb begin
      case (hsv2rgb_pkg::sector_type'(sec2_ff))
         hsv2rgb_pkg::SEC_RED: begin
            pix3_in = '{red: val2_ff, green: t_val, blue: p_val};
         end
         hsv2rgb_pkg::SEC_YELLOW: begin
            pix3_in = '{red: q_val, green: val2_ff, blue: p_val};
         end
         hsv2rgb_pkg::SEC_GREEN: begin
            pix3_in = '{red: p_val, green: val2_ff, blue: t_val};
         end
         hsv2rgb_pkg::SEC_CYAN: begin
            pix3_in = '{red: p_val, green: q_val, blue: val2_ff};
         end
         hsv2rgb_pkg::SEC_BLUE: begin
            pix3_in = '{red: t_val, green: p_val, blue: val2_ff};
         end
         default: begin
            pix3_in = '{red: val2_ff, green: p_val, blue: q_val};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      if (advance) begin
         sec1_ff <= in_sector;
         val1_ff <= in_val;
         fs1_ff  <= {8'd0, in_frac} * {{HUE_BITS{1'b0}}, in_sat};
         fst1_ff <= {8'd0, in_cfrac} * {{(HUE_BITS+1){1'b0}}, in_sat};
         pn1_ff  <= {8'd0, in_val} * {8'd0, 8'd255 - in_sat};
         sec2_ff <= sec1_ff;
         val2_ff <= val1_ff;
         yp2_ff  <= pn1_ff;
         yq2_ff  <= xq[HUE_BITS+15:HUE_BITS];
         yt2_ff  <= xt[HUE_BITS+15:HUE_BITS];
         pix3_ff <= pix3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_pixel = pix3_ff;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_convert.sv
// top level of the hsv to rgb pixel converter
//
// input side is a queue: drive req_hue, req_saturation and req_brightness
// with req_push high; the word is taken at a clock edge where req_full is low.
// result side is a queue too: while rsp_empty is low the oldest result sits
// on rsp_red, rsp_green and rsp_blue; it is taken at an edge with rsp_pop high.
// one pixel goes in and one pixel comes out per clock cycle while the receiver
// keeps popping. from push to the result, a word passes the front register,
// a two-entry queue between front and back, three back stages (products,
// scaled products, divide by 255 and sector routing) and the output queue.
// the back pipeline moves as a whole; when the receiver stops popping, the
// output queue fills, the back stalls, the middle queue fills and req_full
// rises, so no word is dropped. reset (synchronous, active high) empties
// every queue and pipeline stage; there is no other state.
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_convert #(
   parameter int HUE_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [HUE_BITS-1:0] req_hue,
   input  wire logic [7:0]          req_saturation,
   input  wire logic [7:0]          req_brightness,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [7:0]               rsp_red,
   output logic [7:0]               rsp_green,
   output logic [7:0]               rsp_blue
);

   localparam int MID_W = HUE_BITS + 19;
   localparam int PIX_W = $bits(hsv2rgb_pkg::rgb_type);

   logic                 front_push;
   logic                 mid_full;
   logic [MID_W-1:0]     front_word;
   logic                 mid_empty;
   logic [MID_W-1:0]     mid_word;
   logic                 back_ready;
   logic                 back_valid;
   hsv2rgb_pkg::rgb_type back_pixel;
   logic                 out_full;
   logic [PIX_W-1:0]     out_word;
   hsv2rgb_pkg::rgb_type rsp_pixel;

   hsv2rgb_front #(.HUE_BITS(HUE_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .mid_push       (front_push),
      .mid_full       (mid_full),
      .mid_word       (front_word)
   );

   hsv2rgb_queue #(.WIDTH(MID_W)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .full      (mid_full),
      .push_word (front_word),
      .pop       (back_ready),
      .empty     (mid_empty),
      .pop_word  (mid_word)
   );

   hsv2rgb_back #(.HUE_BITS(HUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!mid_empty),
      .in_ready  (back_ready),
      .in_word   (mid_word),
      .out_valid (back_valid),
      .out_ready (!out_full),
      .out_pixel (back_pixel)
   );

   hsv2rgb_queue #(.WIDTH(PIX_W)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .full      (out_full),
      .push_word (back_pixel),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_word  (out_word)
   );

   assign rsp_pixel = hsv2rgb_pkg::rgb_type'(out_word);
   assign rsp_red   = rsp_pixel.red;
   assign rsp_green = rsp_pixel.green;
   assign rsp_blue  = rsp_pixel.blue;

   // a stalled back end keeps its finished pixel
   `ASSERT_NEXT(a_back_hold, clock, reset, back_valid && out_full,
                back_valid && $stable(back_pixel))
   // a front word blocked by the middle queue is not lost
   `ASSERT_NEXT(a_front_hold, clock, reset, front_push && mid_full, front_push)
   // a word waiting in the middle queue stays while the back stalls
   `ASSERT_NEXT(a_mid_hold, clock, reset, !mid_empty && !back_ready, !mid_empty)

endmodule

`default_nettype wire
